FILE: src/isort_pkg.sv
// Shared types for the insertion sort engine: the broadcast control word
// and the link that one sort cell hands to its upper neighbor.
// No dependencies.
package isort_pkg;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;    // insert the broadcast value into the chain
        logic unload;  // shift the chain down by one toward cell 0
    } isort_ctrl_t;

    // Status a cell passes to the next cell up the chain.
    typedef struct packed {
        logic valid;   // the cell holds an element
        logic gt;      // the held element is strictly greater than the new value
    } isort_link_t;

endpackage

FILE: src/isort_cell.sv
// One cell of the insertion chain: holds one element and its valid bit.
// Depends on isort_pkg for the control and link types.
module isort_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  isort_pkg::isort_ctrl_t        ctrl,
    input  logic signed [VALUE_WIDTH-1:0] new_value,
    input  isort_pkg::isort_link_t        prev_link,
    input  logic signed [VALUE_WIDTH-1:0] prev_value,
    input  logic                          upper_valid,
    input  logic signed [VALUE_WIDTH-1:0] upper_value,
    output isort_pkg::isort_link_t        link,
    output logic signed [VALUE_WIDTH-1:0] value
);
    import isort_pkg::*;

    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                          valid_reg, valid_next;
    logic                          gt;
    logic                          takes;

    assign gt = valid_reg && (value_reg > new_value);
    // This cell changes on a load when its element moves up, or when it is
    // the lowest empty cell.
    assign takes = gt || (!valid_reg && prev_link.valid);

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.unload) begin
            value_next = upper_value;
            valid_next = upper_valid;
        end else if (ctrl.load && takes) begin
            value_next = prev_link.gt ? prev_value : new_value;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign value      = value_reg;

endmodule

FILE: src/insertion_sort_engine.sv
// Top level of the insertion sort engine: a chain of sort cells plus the
// load/unload control and the registered result beat. Depends on isort_pkg
// and isort_cell.
//
//   Channel   Ports            Payload
//   --------  ---------------  ---------------------------------------------
//   input     s_t*             tdata: value; tlast: is_last
//   result    m_t*             tdata: sorted_value; tlast: last_of_run;
//                              tuser: overflow
//
// Loading is fully parallel: every cell compares its element with the
// incoming value at once and the chain shifts in a single step.
// When the beat flagged tlast is taken, the chain unloads one element per
// cycle through cell 0 into the output register; s_tready is low while
// unloading. Reset empties the chain and the output register; downstream
// stalls hold the output register and pause the unload.
module insertion_sort_engine #(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // tdata bits from 0: value (VALUE_WIDTH bits), then zero fill
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tlast,
    output logic                                 s_tready,
    // tdata bits from 0: sorted_value (VALUE_WIDTH bits), then zero fill
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic                                 m_tvalid,
    output logic                                 m_tlast,
    // tuser bit 0: overflow
    output logic                                 m_tuser,
    input  logic                                 m_tready
);
    import isort_pkg::*;

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    isort_ctrl_t                   ctrl;
    isort_link_t                   link    [DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]              valid_vec;
    logic signed [VALUE_WIDTH-1:0] new_value;

    logic                   unload_reg, unload_next;
    logic                   dropped_reg, dropped_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic [VALUE_WIDTH-1:0] m_data_reg, m_data_next;

    logic in_beat;
    logic full;
    logic pop;

    assign new_value = $signed(s_tdata[VALUE_WIDTH-1:0]);
    assign s_tready  = !unload_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign full      = valid_vec[DEPTH-1];
    // While unloading, cell 0 moves into the output register whenever that register is free.
    assign pop       = unload_reg && (!m_tvalid_reg || m_tready);

    // Elements that arrive with the chain full are dropped, not inserted.
    assign ctrl.load   = in_beat && !full;
    assign ctrl.unload = pop;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            isort_link_t                   p_link;
            logic signed [VALUE_WIDTH-1:0] p_val;
            logic                          u_valid;
            logic signed [VALUE_WIDTH-1:0] u_val;

            // Below cell 0 sits a virtual full cell that is never greater,
            // so an empty cell 0 always accepts the new value.
            if (i == 0) begin : g_bottom
                assign p_link.valid = 1'b1;
                assign p_link.gt    = 1'b0;
                assign p_val        = '0;
            end else begin : g_inner
                assign p_link = link[i-1];
                assign p_val  = cell_val[i-1];
            end

            if (i == DEPTH - 1) begin : g_top
                assign u_valid = 1'b0;
                assign u_val   = '0;
            end else begin : g_below_top
                assign u_valid = link[i+1].valid;
                assign u_val   = cell_val[i+1];
            end

            isort_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_value  (new_value),
                .prev_link  (p_link),
                .prev_value (p_val),
                .upper_valid(u_valid),
                .upper_value(u_val),
                .link       (link[i]),
                .value      (cell_val[i])
            );

            assign valid_vec[i] = link[i].valid;
        end
    endgenerate

    always_comb begin
        unload_next   = unload_reg;
        dropped_next  = dropped_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        m_data_next   = m_data_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (in_beat) begin
            if (full) begin
                dropped_next = 1'b1;
            end
            if (s_tlast) begin
                unload_next = 1'b1;
            end
        end

        if (pop) begin
            m_tvalid_next = 1'b1;
            m_data_next   = cell_val[0];
            m_tuser_next  = dropped_reg;
            // The run ends when nothing sits above cell 0.
            m_tlast_next  = !valid_vec[1];
            if (!valid_vec[1]) begin
                unload_next  = 1'b0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
        if (!aresetn) begin
            unload_reg   <= 1'b0;
            dropped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unload_reg   <= unload_next;
            dropped_reg  <= dropped_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

    // The occupied cells always form one contiguous block starting at cell 0.
    a_contiguous : assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("sort chain occupancy is not contiguous");

    // The beat that closes a set always starts an unload.
    a_tlast_unloads : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_tlast) |=> unload_reg)
        else $error("closing beat did not start unload");

    // While unloading, the chain still holds at least one element.
    a_unload_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        unload_reg |-> valid_vec[0])
        else $error("unload running on an empty chain");

    // Moving the final element of a run out of the chain ends the unload.
    a_last_ends_run : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !valid_vec[1]) |=> !unload_reg)
        else $error("unload still active after final result beat");

endmodule

FILE: sim/insertion_sort_engine_test.sv
// Self-checking testbench for insertion_sort_engine: streams sets of signed values with
// random gaps and stalls, predicts each sorted run in a local model and checks every beat.
// Depends only on the RTL (insertion_sort_engine and what it instantiates).
`timescale 1ns / 1ps

module insertion_sort_engine_test;

    localparam int DEPTH        = 32;
    localparam int VW           = 32;
    localparam int DW           = ((VW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int REPORT_MAX   = 10;

    // One beat of the sorted output run.
    typedef struct packed {
        logic [VW-1:0] value;
        logic          run_end;
        logic          overflow;
    } sorted_beat_t;

    // One row of directed stimulus. Rows with typed set carry a hand-written result;
    // they are always single-element sets, so exactly one result beat follows.
    typedef struct packed {
        logic [VW-1:0] value;
        logic          is_last;
        logic          typed;
        sorted_beat_t  want;
    } stim_row_t;

    logic          aclk;
    logic          aresetn;
    logic [DW-1:0] s_tdata;
    logic          s_tvalid;
    logic          s_tlast;
    logic          s_tready;
    logic [DW-1:0] m_tdata;
    logic          m_tvalid;
    logic          m_tlast;
    logic          m_tuser;
    logic          m_tready;

    insertion_sort_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tready (m_tready)
    );

    // Directed sets: lone extremes right after reset, then a mixed set with duplicates
    // and both ends of the range, then an ascending and a descending set.
    stim_row_t directed_rows [20] = '{
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0004, 1'b1, 1'b0, '0},
        '{32'h0000_0004, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b1, 1'b0, '0}
    };

    // Local copy of the sorter state.
    logic signed [VW-1:0] sort_store [DEPTH];
    int                   sort_fill;
    bit                   sort_dropped;

    sorted_beat_t sorted_run_q [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int cycle_count;
    int beats_sent;
    int sets_closed;
    int overflow_sets;
    int results_seen;
    int mismatches;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d sorted beats still expected",
                     cycle_count, sorted_run_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Insert one accepted value into the local sorted store; on the last beat of a set,
    // queue the whole run in ascending order and empty the store.
    task automatic sort_insert(input logic [VW-1:0] value, input logic is_last);
        int pos;
        sorted_beat_t run_beat;
        if (sort_fill < DEPTH) begin
            pos = sort_fill;
            // Strictly greater keeps equal values in arrival order.
            while (pos > 0 && sort_store[pos-1] > $signed(value)) begin
                sort_store[pos] = sort_store[pos-1];
                pos--;
            end
            sort_store[pos] = value;
            sort_fill++;
        end else begin
            sort_dropped = 1'b1;
        end
        if (is_last) begin
            for (int k = 0; k < sort_fill; k++) begin
                run_beat.value    = sort_store[k];
                run_beat.run_end  = (k == sort_fill - 1);
                run_beat.overflow = sort_dropped;
                sorted_run_q.push_back(run_beat);
            end
            sets_closed++;
            if (sort_dropped)
                overflow_sets++;
            sort_fill    = 0;
            sort_dropped = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Offer one beat, holding it until it is taken, then predict its results.
    task automatic send_beat(input stim_row_t row);
        int before_cnt;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = row.value;
        s_tlast  = row.is_last;
        s_tvalid = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        beats_sent++;
        before_cnt = sorted_run_q.size();
        sort_insert(row.value, row.is_last);
        if (row.typed) begin
            // Swap the predicted beat for the one written in the row.
            while (sorted_run_q.size() > before_cnt)
                void'(sorted_run_q.pop_back());
            sorted_run_q.push_back(row.want);
        end
        @(negedge aclk);
    endtask

    function automatic logic [VW-1:0] random_element();
        logic [VW-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom();
            2: v = VW'($urandom_range(0, 8)) - VW'(4);   // crowd around zero for ties
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom() & 32'h8000_00FF;
        endcase
        return v;
    endfunction

    task automatic send_set(input int set_size);
        stim_row_t row;
        for (int i = 0; i < set_size; i++) begin
            row         = '0;
            row.value   = random_element();
            row.is_last = (i == set_size - 1);
            send_beat(row);
        end
    endtask

    // Mostly short sets; now and then a full store or one that overflows.
    task automatic send_random_sets(input int beat_goal);
        while (beats_sent < beat_goal) begin
            if ($urandom_range(0, 9) == 0)
                send_set(DEPTH + $urandom_range(0, 8));
            else
                send_set($urandom_range(1, 12));
        end
    endtask

    // Result side: drives m_tready at the falling edge. A hold request stalls the output
    // for a long stretch so an unload stalls and the sorter back-pressures its input.
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Compare every taken result beat with the oldest expected one.
    always @(posedge aclk) begin
        sorted_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (sorted_run_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat value=%h last=%b overflow=%b",
                                        m_tdata, m_tlast, m_tuser));
            end else begin
                want = sorted_run_q.pop_front();
                if (m_tdata !== DW'(want.value) || m_tlast !== want.run_end
                        || m_tuser !== want.overflow)
                    note_mismatch($sformatf(
                        "expected value=%h last=%b overflow=%b, got value=%h last=%b overflow=%b",
                        want.value, want.run_end, want.overflow, m_tdata, m_tlast, m_tuser));
            end
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tdata       = '0;
        s_tvalid      = 1'b0;
        s_tlast       = 1'b0;
        tx_idle_pct   = 33;
        rx_idle_pct   = 77;
        hold_requests = 0;
        cycle_count   = 0;
        beats_sent    = 0;
        sets_closed   = 0;
        overflow_sets = 0;
        results_seen  = 0;
        mismatches    = 0;
        sort_fill     = 0;
        sort_dropped  = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            sort_store[i] = '0;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Phase one: slow receiver.
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        // Exactly full store, then one more than fits with the dropped beat being last.
        send_set(DEPTH);
        send_set(DEPTH + 1);
        send_random_sets(130);

        // Phase two: slow sender.
        tx_idle_pct = 77;
        rx_idle_pct = 33;
        send_random_sets(250);

        // Phase three: no idling, with one long output stall over an overflowing set
        // while the next set keeps being offered.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        send_set(DEPTH + 8);
        send_random_sets(360);

        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        wait (sorted_run_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sorted %0d sets from %0d input beats (%0d sets over capacity), %0d result beats.",
                 sets_closed, beats_sent, overflow_sets, results_seen);
        $display("Result mismatches: %0d", mismatches);
        if (mismatches == 0 && sorted_run_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
